// ===== sv/byte_frames_to_word36_unpacker_unit_assert.svh =====
// Assertion macros shared by the unpacker RTL.
// Taken in by `include; no other dependencies.
`ifndef BYTE_FRAMES_TO_WORD36_UNPACKER_UNIT_ASSERT_SVH
`define BYTE_FRAMES_TO_WORD36_UNPACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, held off while reset is asserted.
`define BFU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define BFU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BFU_ASSERT(label, clk, rstn, prop, msg)
`define BFU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== sv/bfu_pkg.sv =====
// Package for the byte-frame to 36-bit word unpacker.
// Types, constants and register indexes; no dependencies.
package bfu_pkg;

    typedef enum logic [1:0] {
        FMT_A = 2'd0,
        FMT_B = 2'd1,
        FMT_C = 2'd2,
        FMT_D = 2'd3
    } bfu_fmt_t;

    typedef enum logic [1:0] {
        REG_FRAME_FORMAT = 2'd0,
        REG_SKIP_ENABLE  = 2'd1,
        REG_WORD_LIMIT   = 2'd2
    } bfu_reg_idx_t;

    localparam int CFG_DATA_W = 16;
    localparam int WORD_W     = 36;
    localparam int BYTES_W    = 19;
    localparam int WORDS_W    = 16;
    localparam int RESID_W    = 4;

    // Frame group sizes, format C split positions and the last positions of formats A and B
    localparam logic [3:0] GRP_QUARTER = 4'd4;
    localparam logic [3:0] GRP_SIXTH   = 4'd6;
    localparam logic [3:0] GRP_PACKED  = 4'd9;
    localparam logic [3:0] C_SPLIT_POS = 4'd4;
    localparam logic [3:0] C_EVEN_POS  = 4'd5;
    localparam logic [3:0] C_LAST_POS  = 4'd8;
    localparam logic [3:0] B_LAST_POS  = 4'd5;
    localparam logic [3:0] A_LAST_POS  = 4'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        bfu_fmt_t              frame_format;
        logic                  skip_enable;
        logic [WORDS_W-1:0]    word_limit;
    } bfu_cfg_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       dest_skip;
        logic       last_byte;
    } bfu_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word_value;
        logic               word_valid;
        logic               store_word;
        logic               is_last;
        logic [BYTES_W-1:0] byte_count;
        logic [WORDS_W-1:0] word_tally;
        logic [RESID_W-1:0] residue;
    } bfu_result_t;

    // What one beat produces: up to two results, in order
    typedef struct packed {
        logic [1:0]  nres;
        bfu_result_t res0;
        bfu_result_t res1;
    } bfu_step_t;

endpackage

// ===== sv/bfu_pack.sv =====
// Packing datapath: transfer state and the one-beat step into up to two words.
// Depends on bfu_pkg and the assertion macro header.
`include "byte_frames_to_word36_unpacker_unit_assert.svh"

module bfu_pack (
    input  logic               aclk,
    input  logic               aresetn,
    input  bfu_pkg::bfu_cfg_t  cfg,
    input  bfu_pkg::bfu_item_t item,
    input  logic               en,
    output bfu_pkg::bfu_step_t step
);
    import bfu_pkg::*;

    logic [WORD_W-1:0]  acc_reg,   acc_next;
    logic [3:0]         nib_reg,   nib_next;
    logic [3:0]         pos_reg,   pos_next;
    logic [WORDS_W-1:0] words_reg, words_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [2:0]         mod6_reg,  mod6_next;
    logic [3:0]         mod9_reg,  mod9_next;

    logic [3:0]         grp, pos0, pos2;
    logic [WORD_W-1:0]  acc0, acc1, acc2, acc3, ins_val, first_word;
    logic [3:0]         nib0, nib1;
    logic [5:0]         sh;
    logic               active, done, store, first_done, partial, first, even, is_c;
    logic               wrap;
    logic [BYTES_W-1:0] bytes1;
    logic [2:0]         mod6_1;
    logic [3:0]         mod9_1, resid;
    logic [WORDS_W-1:0] words_a, words_f, words_e;
    bfu_result_t        r_first, r_even, r_stat;

    always_comb begin
        is_c = (cfg.frame_format == FMT_C);
        case (cfg.frame_format)
            FMT_B:   grp = GRP_SIXTH;
            FMT_C:   grp = GRP_PACKED;
            default: grp = GRP_QUARTER;
        endcase

        // new group after a format change leaves the position out of range
        if (pos_reg >= grp) begin
            pos0 = '0;
            acc0 = '0;
            nib0 = '0;
        end else begin
            pos0 = pos_reg;
            acc0 = acc_reg;
            nib0 = nib_reg;
        end

        active = (words_reg < cfg.word_limit);
        store  = !(item.dest_skip & cfg.skip_enable);

        // byte count and running residues, kept in step with the 19-bit wrap
        wrap = &bytes_reg;
        if (active) begin
            bytes1 = bytes_reg + 19'd1;
            mod6_1 = (wrap || mod6_reg == 3'd5) ? 3'd0 : mod6_reg + 3'd1;
            mod9_1 = (wrap || mod9_reg == 4'd8) ? 4'd0 : mod9_reg + 4'd1;
        end else begin
            bytes1 = bytes_reg;
            mod6_1 = mod6_reg;
            mod9_1 = mod9_reg;
        end

        // field placement
        ins_val = {28'd0, item.frame_byte};
        sh      = '0;
        nib1    = nib0;
        done    = 1'b0;
        case (cfg.frame_format)
            FMT_B: begin
                ins_val = {30'd0, item.frame_byte[5:0]};
                sh      = 6'd30 - 6'(pos0) * 6'd6;
                done    = (pos0 == B_LAST_POS);
            end
            FMT_C: begin
                if (pos0 < C_SPLIT_POS) begin
                    sh = 6'd28 - 6'({pos0, 3'b000});
                end else if (pos0 == C_SPLIT_POS) begin
                    ins_val = {32'd0, item.frame_byte[7:4]};
                    nib1    = active ? item.frame_byte[3:0] : nib0;
                    done    = 1'b1;
                end else begin
                    sh   = 6'({C_LAST_POS - pos0, 3'b000});
                    done = (pos0 == C_LAST_POS);
                end
            end
            default: begin
                sh   = 6'd27 - 6'(pos0) * 6'd9;
                done = (pos0 == A_LAST_POS);
            end
        endcase

        acc1 = acc0 | (ins_val << sh);

        if (!active) begin
            acc2 = acc0;
            pos2 = pos0;
        end else if (done && is_c && pos0 == C_SPLIT_POS) begin
            acc2 = {nib1, 32'd0};
            pos2 = C_EVEN_POS;
        end else if (done) begin
            acc2 = '0;
            pos2 = '0;
        end else begin
            acc2 = acc1;
            pos2 = pos0 + 4'd1;
        end

        // words out of this beat: finished or padded word, then the even partner
        first_done = active & done;
        partial    = active & item.last_byte & (pos2 != 4'd0) &
                     (!is_c || pos2 < C_EVEN_POS);
        first      = first_done | partial;
        first_word = first_done ? acc1 : acc2;
        words_a    = words_reg + 16'd1;
        words_f    = first ? words_a : words_reg;
        acc3       = partial ? '0 : acc2;
        even       = active & item.last_byte & is_c & (pos2 != 4'd0) &
                     (words_f < cfg.word_limit);
        words_e    = words_f + 16'd1;

        case (cfg.frame_format)
            FMT_B:   resid = {1'b0, mod6_1};
            FMT_C:   resid = (mod9_1 == C_EVEN_POS) ? 4'd0 : mod9_1;
            default: resid = {2'b00, bytes1[1:0]};
        endcase

        r_first = '{word_value: first_word, word_valid: 1'b1, store_word: store,
                    is_last: item.last_byte & !even, byte_count: bytes1,
                    word_tally: words_a, residue: (item.last_byte & !even) ? resid : 4'd0};
        r_even  = '{word_value: acc3, word_valid: 1'b1, store_word: store,
                    is_last: 1'b1, byte_count: bytes1,
                    word_tally: words_e, residue: resid};
        r_stat  = '{word_value: '0, word_valid: 1'b0, store_word: 1'b0,
                    is_last: 1'b1, byte_count: bytes1,
                    word_tally: words_reg, residue: resid};

        if (first) begin
            step.res0 = r_first;
            step.res1 = r_even;
            step.nres = even ? 2'd2 : 2'd1;
        end else if (even) begin
            step.res0 = r_even;
            step.res1 = r_even;
            step.nres = 2'd1;
        end else begin
            step.res0 = r_stat;
            step.res1 = r_stat;
            step.nres = item.last_byte ? 2'd1 : 2'd0;
        end

        if (item.last_byte) begin
            acc_next   = '0;
            nib_next   = '0;
            pos_next   = '0;
            words_next = '0;
            bytes_next = '0;
            mod6_next  = '0;
            mod9_next  = '0;
        end else begin
            acc_next   = acc2;
            nib_next   = nib1;
            pos_next   = pos2;
            words_next = words_f;
            bytes_next = bytes1;
            mod6_next  = mod6_1;
            mod9_next  = mod9_1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            nib_reg   <= '0;
            pos_reg   <= '0;
            words_reg <= '0;
            bytes_reg <= '0;
            mod6_reg  <= '0;
            mod9_reg  <= '0;
        end else if (en) begin
            acc_reg   <= acc_next;
            nib_reg   <= nib_next;
            pos_reg   <= pos_next;
            words_reg <= words_next;
            bytes_reg <= bytes_next;
            mod6_reg  <= mod6_next;
            mod9_reg  <= mod9_next;
        end
    end

    `BFU_ASSERT(a_last_clears, aclk, aresetn, (en && item.last_byte) |=> (words_reg == '0 && pos_reg == '0 && bytes_reg == '0), "transfer state not cleared after last beat")
    `BFU_ASSERT(a_pair_only_c, aclk, aresetn, (step.nres == 2'd2) |-> (cfg.frame_format == FMT_C && item.last_byte), "two words from one beat outside a format C end")
    `BFU_ASSERT(a_limit_drop, aclk, aresetn, (en && !item.last_byte && words_reg >= cfg.word_limit) |=> $stable(bytes_reg), "byte counted past word limit")

endmodule

// ===== sv/bfu_out_fifo.sv =====
// Result queue: four entries, takes up to two results a cycle, gives one.
// Depends on bfu_pkg and the assertion macro header.
`include "byte_frames_to_word36_unpacker_unit_assert.svh"

module bfu_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            push_n,
    input  bfu_pkg::bfu_result_t  push0,
    input  bfu_pkg::bfu_result_t  push1,
    input  logic                  pop,
    output logic                  out_valid,
    output bfu_pkg::bfu_result_t  out_data,
    output logic [bfu_pkg::FIFO_AW:0] count
);
    import bfu_pkg::*;

    bfu_result_t        mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] head_reg, head_next;
    logic [FIFO_AW-1:0] tail_reg, tail_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_pop;

    assign do_pop    = pop & (count_reg != '0);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[head_reg];
    assign count     = count_reg;

    always_comb begin
        head_next  = do_pop ? head_reg + 1'b1 : head_reg;
        tail_next  = tail_reg + FIFO_AW'(push_n);
        count_next = count_reg + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[tail_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem[tail_reg + 1'b1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    `BFU_ASSERT(a_no_overflow, aclk, aresetn, ((FIFO_AW + 2)'(count_reg) + (FIFO_AW + 2)'(push_n) <= (FIFO_AW + 2)'(FIFO_DEPTH)), "result queue overflow")
    `BFU_ASSERT(a_ptr_gap, aclk, aresetn, (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH)) || (FIFO_AW'(count_reg) == FIFO_AW'(tail_reg - head_reg)), "queue pointers disagree with fill")
    `BFU_ASSERT(a_pop_count, aclk, aresetn, (do_pop && push_n == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1), "pop did not lower fill")

endmodule

// ===== sv/byte_frames_to_word36_unpacker_unit.sv =====
// Top level of the byte-frame to 36-bit word unpacker.
// Depends on bfu_pkg, bfu_pack, bfu_out_fifo and the assertion macro header.
//
// Device byte frames come in one beat at a time and leave as 36-bit words with
// count and residue status. Format A/D places each byte in the low 8 bits of
// 9-bit quarter-words, format B packs the low 6 bits into sixth-words, and
// format C packs nine bytes into an odd/even word pair with byte 4 split
// across them. Bytes past word_limit are dropped uncounted. The last beat pads
// a partial word with zeros (and in format C also sends the even partner);
// if it sends no word, a status-only beat (tuser word_valid low) carries the
// counts. The last result has tlast, and a residue of bytes mod 4, 6 or 9 (C: 5 gives 0).
// A beat is packed combinationally while it sits in the input register, and its
// results are then written into a four-entry result queue, from whose head
// they are taken on m_.
// One beat is taken per cycle; a beat whose results do not fit in the free
// places of the queue waits in the input register with s_tready low. With
// m_tready held high that only happens after a run of two-word last beats.
// Configuration writes are taken at any time but must only land while idle.
`include "byte_frames_to_word36_unpacker_unit_assert.svh"

module byte_frames_to_word36_unpacker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [bfu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // byte frames in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tuser,   // [0] dest_skip
    input  logic        s_tlast,   // last_byte
    // words out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [35:0] word_value, [54:36] byte_count,
                                   // [70:55] word count, [74:71] residue, rest 0
    output logic [1:0]  m_tuser,   // [0] word_valid, [1] store_word
    output logic        m_tlast    // is_last
);
    import bfu_pkg::*;

    bfu_cfg_t    cfg_reg;
    bfu_item_t   in_reg;
    logic        in_valid_reg, in_valid_next;
    logic        s_fire, consume, room;
    bfu_step_t   step;
    bfu_result_t head;
    logic [FIFO_AW:0] q_count;
    logic [1:0]  push_n;

    // config registers; writes to an unused index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{frame_format: FMT_A, skip_enable: 1'b0, word_limit: '0};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_FORMAT: cfg_reg.frame_format <= bfu_fmt_t'(cfg_wdata[1:0]);
                REG_SKIP_ENABLE:  cfg_reg.skip_enable  <= cfg_wdata[0];
                REG_WORD_LIMIT:   cfg_reg.word_limit   <= cfg_wdata[WORDS_W-1:0];
                default: ;
            endcase
        end
    end

    // the queue has room for everything the held beat will produce
    assign room    = ((FIFO_AW + 2)'(q_count) + (FIFO_AW + 2)'(step.nres))
                     <= (FIFO_AW + 2)'(FIFO_DEPTH);
    assign consume = in_valid_reg & room;
    assign s_tready = !in_valid_reg || consume;
    assign s_fire   = s_tvalid & s_tready;
    assign push_n   = consume ? step.nres : 2'd0;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= '{frame_byte: s_tdata, dest_skip: s_tuser, last_byte: s_tlast};
        end
    end

    bfu_pack u_pack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (in_reg),
        .en      (consume),
        .step    (step)
    );

    bfu_out_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (step.res0),
        .push1     (step.res1),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (head),
        .count     (q_count)
    );

    assign m_tdata = {5'd0, head.residue, head.word_tally, head.byte_count, head.word_value};
    assign m_tuser = {head.store_word, head.word_valid};
    assign m_tlast = head.is_last;

    `BFU_ASSERT(a_hold_beat, aclk, aresetn, (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_reg)), "held beat lost or changed before packing")
    `BFU_ASSERT(a_no_take_full, aclk, aresetn, (in_valid_reg && !consume) |-> !s_tready, "input taken while held beat is waiting")
    `BFU_ASSERT_ALWAYS(a_reset_idle, aclk, !$past(aresetn) |-> (!in_valid_reg && !m_tvalid), "block not idle after reset")

endmodule
